### hdl/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the bitmap frame allocator: field widths,
// command codes, controller states and the bit search result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bfa_pkg;

  // bitmap geometry
  localparam int unsigned WORD_BITS  = 32;
  localparam int unsigned BIT_W      = 5;
  localparam int unsigned FRAMES_DEF = 16384;

  // transaction field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned FRAME_W = 14;
  localparam int unsigned COUNT_W = 15;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESERVE = 2'd2;

  // controller states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_DONE
  } bfa_state_e;

  // lowest set bit of a bitmap word
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] idx;
  } bfa_seg_t;

endpackage

### hdl/bfa_if.sv
// ----------------------------------------------------------------------------
// bfa_req_if / bfa_rsp_if
// Valid/ready channels of the bitmap frame allocator: command requests in,
// one response per request out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bfa_req_if import bfa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [FRAME_W-1:0] frame;
  logic [COUNT_W-1:0] count;

  modport source (output valid, output cmd, output frame, output count, input ready);
  modport sink   (input valid, input cmd, input frame, input count, output ready);
endinterface

interface bfa_rsp_if import bfa_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] frame_out;
  logic               ok;

  modport source (output valid, output frame_out, output ok, input ready);
  modport sink   (input valid, input frame_out, input ok, output ready);
endinterface

### hdl/bfa_map_ram.sv
// ----------------------------------------------------------------------------
// bfa_map_ram
// Used-frame bitmap storage: one write port and one read port, read data
// registered, read returns old data on a same-cycle write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfa_map_ram import bfa_pkg::*; #(
  parameter int unsigned Depth = FRAMES_DEF / WORD_BITS,
  parameter int unsigned AddrW = $clog2(FRAMES_DEF / WORD_BITS)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  logic [WORD_BITS-1:0] wdata_i,
  input  logic [AddrW-1:0]     raddr_i,
  output logic [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

### hdl/bfa_seg_find.sv
// ----------------------------------------------------------------------------
// bfa_seg_find
// Finds the lowest set bit of a bitmap word; used to find where the current
// stretch of free or used frames ends inside a word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfa_seg_find import bfa_pkg::*; (
  input  logic [WORD_BITS-1:0] vec_i,
  output bfa_seg_t             seg_o
);

  // priority pick, lowest index wins
  always_comb begin
    seg_o = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (vec_i[i]) begin
        seg_o.found = 1'b1;
        seg_o.idx   = BIT_W'(i);
      end
    end
  end

endmodule

### hdl/bitmap_frame_allocator_top.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_top
// Next-fit bitmap frame allocator. One bit per frame (1 = used) kept in a
// word-wide synchronous RAM; allocate searches for a free run from the hint,
// free and reserve clear or set a range of frames.
//
//   channel | dir | handshake        | payload
//   req_i   | in  | valid / ready    | cmd, frame, count
//   rsp_o   | out | valid / ready    | frame_out, ok
//
// After reset an init pass marks all frames used, one bitmap word per cycle
// (FRAMES/32 words, 512 at the default); requests wait for it. One request at
// a time: allocate scans one stretch of free or used frames per step in each
// word (a fully used word is a single step), then marks the run word by word;
// free/reserve mark each word touched; plus an accept and a hand-off step.
// A response held on a stalled rsp_o does not block the next request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bitmap_frame_allocator_top import bfa_pkg::*; #(
  parameter int unsigned FRAMES = FRAMES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bfa_req_if.sink   req_i,
  bfa_rsp_if.source rsp_o
);

  localparam int unsigned FrmW   = $clog2(FRAMES);
  localparam int unsigned PosW   = (FrmW + 1 > 16) ? FrmW + 1 : 16;
  localparam int unsigned WordsN = FRAMES / WORD_BITS;
  localparam int unsigned AddrW  = $clog2(WordsN);

  localparam logic [PosW-1:0]      FramesP  = PosW'(FRAMES);
  localparam logic [AddrW-1:0]     LastWord = AddrW'(WordsN - 1);
  localparam logic [WORD_BITS-1:0] Ones     = {WORD_BITS{1'b1}};

  bfa_state_e state_q, state_d;

  logic [AddrW-1:0]   init_q, init_d;
  logic [PosW-1:0]    pos_q, pos_d;
  logic [PosW-1:0]    lim_q, lim_d;
  logic [PosW-1:0]    start_q, start_d;
  logic [PosW-1:0]    end_q, end_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic [COUNT_W-1:0] run_q, run_d;
  logic               pass_q, pass_d;
  logic               set_q, set_d;
  logic [FrmW-1:0]    hint_q, hint_d;
  logic [FRAME_W-1:0] res_frame_q, res_frame_d;
  logic               res_ok_q, res_ok_d;
  logic               rsp_valid_q, rsp_valid_d;
  logic [FRAME_W-1:0] rsp_frame_q, rsp_frame_d;
  logic               rsp_ok_q, rsp_ok_d;

  // bitmap memory ports
  logic                 ram_we;
  logic [AddrW-1:0]     ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AddrW-1:0]     ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  // word position of the current frame
  logic [PosW-1:0]      word_base;
  logic [PosW-1:0]      word_end;
  logic [BIT_W-1:0]     bit_idx;

  // scan step
  logic [PosW-1:0]      cap;
  logic                 cur_free;
  logic [WORD_BITS-1:0] above;
  logic [WORD_BITS-1:0] srch;
  bfa_seg_t             seg;
  logic [PosW-1:0]      nxt;
  logic [PosW-1:0]      seg_end;
  logic [BIT_W:0]       seg_len;
  logic [COUNT_W:0]     total;
  logic [PosW-1:0]      run_base;
  logic                 hit;
  logic [PosW-1:0]      alloc_end;

  // mark step
  logic [WORD_BITS-1:0] mk_mask;

  // request decode
  logic [PosW-1:0]      fr_lo;
  logic [PosW-1:0]      fr_sum;
  logic [PosW-1:0]      fr_end;

  bfa_map_ram #(
    .Depth (WordsN),
    .AddrW (AddrW)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bfa_seg_find u_seg_find (
    .vec_i (srch),
    .seg_o (seg)
  );

  // word of the frame under work; read data always belongs to pos_q
  assign word_base = {pos_q[PosW-1:BIT_W], BIT_W'(0)};
  assign word_end  = word_base + PosW'(WORD_BITS);
  assign bit_idx   = pos_q[BIT_W-1:0];
  assign ram_raddr = pos_d[AddrW+BIT_W-1:BIT_W];

  // find the end of the current free or used stretch in this word
  always_comb begin
    cap       = (lim_q < word_end) ? lim_q : word_end;
    cur_free  = ~ram_rdata[bit_idx];
    above     = (Ones << bit_idx) << 1;
    srch      = (cur_free ? ram_rdata : ~ram_rdata) & above;
    nxt       = seg.found ? (word_base | PosW'(seg.idx)) : word_end;
    seg_end   = (nxt < cap) ? nxt : cap;
    seg_len   = (BIT_W + 1)'(seg_end - pos_q);
    total     = {1'b0, run_q} + (COUNT_W + 1)'(seg_len);
    run_base  = (run_q == '0) ? pos_q : start_q;
    hit       = cur_free && (total >= {1'b0, cnt_q});
    alloc_end = run_base + PosW'(cnt_q);
  end

  // bits of this word inside [pos_q, end_q)
  always_comb begin
    mk_mask = Ones << bit_idx;
    if (end_q < word_end) begin
      mk_mask = mk_mask & ~(Ones << end_q[BIT_W-1:0]);
    end
  end

  // free/reserve range, clipped at the end of the bitmap
  always_comb begin
    fr_lo  = PosW'(req_i.frame);
    fr_sum = fr_lo + PosW'(req_i.count);
    fr_end = (fr_sum > FramesP) ? FramesP : fr_sum;
  end

  // next state and datapath control
  always_comb begin
    state_d     = state_q;
    init_d      = init_q;
    pos_d       = pos_q;
    lim_d       = lim_q;
    start_d     = start_q;
    end_d       = end_q;
    cnt_d       = cnt_q;
    run_d       = run_q;
    pass_d      = pass_q;
    set_d       = set_q;
    hint_d      = hint_q;
    res_frame_d = res_frame_q;
    res_ok_d    = res_ok_q;
    rsp_valid_d = rsp_valid_q;
    rsp_frame_d = rsp_frame_q;
    rsp_ok_d    = rsp_ok_q;
    ram_we      = 1'b0;
    ram_waddr   = pos_q[AddrW+BIT_W-1:BIT_W];
    ram_wdata   = set_q ? (ram_rdata | mk_mask) : (ram_rdata & ~mk_mask);
    req_i.ready = 1'b0;

    // output register drains independently
    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = init_q;
        ram_wdata = Ones;
        init_d    = init_q + AddrW'(1);
        if (init_q == LastWord) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          cnt_d       = req_i.count;
          res_frame_d = '0;
          res_ok_d    = 1'b0;
          state_d     = ST_DONE;
          if (req_i.count != '0) begin
            unique case (req_i.cmd) inside
              CMD_ALLOC: begin
                pos_d   = PosW'(hint_q);
                lim_d   = FramesP;
                pass_d  = 1'b0;
                run_d   = '0;
                start_d = '0;
                set_d   = 1'b1;
                state_d = ST_SCAN;
              end
              CMD_FREE, CMD_RESERVE: begin
                res_ok_d = 1'b1;
                set_d    = (req_i.cmd == CMD_RESERVE);
                if (fr_lo < fr_end) begin
                  pos_d   = fr_lo;
                  end_d   = fr_end;
                  state_d = ST_MARK;
                end
              end
              default: begin
                res_ok_d = 1'b0;
              end
            endcase
          end
        end
      end

      ST_SCAN: begin
        if (hit) begin
          // run found: mark it and move the hint past it
          pos_d       = run_base;
          end_d       = alloc_end;
          hint_d      = (alloc_end >= FramesP) ? '0 : alloc_end[FrmW-1:0];
          res_frame_d = run_base[FRAME_W-1:0];
          res_ok_d    = 1'b1;
          state_d     = ST_MARK;
        end else begin
          pos_d   = seg_end;
          run_d   = cur_free ? total[COUNT_W-1:0] : '0;
          start_d = run_base;
          if (seg_end == lim_q) begin
            // end of a pass: wrap once to frame 0, a run never spans it
            run_d = '0;
            if (!pass_q && (hint_q != '0)) begin
              pass_d = 1'b1;
              pos_d  = '0;
              lim_d  = PosW'(hint_q);
            end else begin
              state_d = ST_DONE;
            end
          end
        end
      end

      ST_MARK: begin
        ram_we = 1'b1;
        pos_d  = word_end;
        if (word_end >= end_q) begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d = 1'b1;
          rsp_frame_d = res_frame_q;
          rsp_ok_d    = res_ok_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      init_q      <= '0;
      hint_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_q      <= init_d;
      hint_q      <= hint_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    lim_q       <= lim_d;
    start_q     <= start_d;
    end_q       <= end_d;
    cnt_q       <= cnt_d;
    run_q       <= run_d;
    pass_q      <= pass_d;
    set_q       <= set_d;
    res_frame_q <= res_frame_d;
    res_ok_q    <= res_ok_d;
    rsp_frame_q <= rsp_frame_d;
    rsp_ok_q    <= rsp_ok_d;
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.frame_out = rsp_frame_q;
  assign rsp_o.ok        = rsp_ok_q;

endmodule

### sim/bitmap_frame_allocator_top_test.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_top_test
// Self-checking bench for the next-fit bitmap frame allocator. A directed
// table covers the empty and full map, count zero, the unused command code,
// the first and last frame, frames past the end, runs that would cross the
// wrap and fully used words. Random traffic follows: allocations, frees of
// previously granted blocks, and noise. Every response is checked against a
// grant from a shadow bitmap kept by the bench, or a hand-written one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bitmap_frame_allocator_top_test;
  import bfa_pkg::*;

  localparam int unsigned FRAMES       = FRAMES_DEF;
  localparam int unsigned MAP_WORDS    = FRAMES / WORD_BITS;
  localparam int unsigned N_DIRECTED   = 25;
  localparam int unsigned RAND_ITEMS   = 1100;
  localparam int unsigned WIPE_EVERY   = 200;
  localparam int unsigned PAUSE_AT     = 600;
  localparam int unsigned HOLD_AFTER   = 300;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned MAX_PRINTS   = 50;
  // worst case per request: 32 stretches in each of 512 words, 512 words marked,
  // plus the longest stalls on both sides; ~1125 requests, taken about 3x over
  localparam longint      LIMIT_CYCLES = 64_000_000;
  localparam int          NO_FRAME     = -1;

  // command code the block does not define
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_out;
    logic               ok;
  } grant_t;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [FRAME_W-1:0] frame;
    logic [COUNT_W-1:0] count;
    bit                 typed;
    grant_t             want;
  } directed_row_t;

  typedef struct {
    int unsigned base;
    int unsigned len;
  } block_t;

  logic clk;
  logic rst_n;

  bfa_req_if req_if ();
  bfa_rsp_if rsp_if ();

  bitmap_frame_allocator_top #(
    .FRAMES(FRAMES)
  ) u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // shadow copy of the allocator state
  logic [WORD_BITS-1:0] shadow_map [MAP_WORDS];
  int unsigned          shadow_hint;

  grant_t      awaited_grants [$];
  block_t      held_blocks [$];
  int unsigned mismatches;
  bit          sender_quiet;

  // directed requests; typed rows carry a hand-written expected grant
  directed_row_t directed_rows [N_DIRECTED] = '{
    '{CMD_ALLOC,   14'd0,     15'd1,     1'b1, {14'd0,     1'b0}}, // map full after reset
    '{CMD_ALLOC,   14'd0,     15'd0,     1'b1, {14'd0,     1'b0}}, // count zero
    '{CMD_FREE,    14'd100,   15'd0,     1'b1, {14'd0,     1'b0}},
    '{CMD_RESERVE, 14'd100,   15'd0,     1'b1, {14'd0,     1'b0}},
    '{CMD_UNUSED,  14'd5,     15'd5,     1'b1, {14'd0,     1'b0}}, // unknown command
    '{CMD_FREE,    14'd0,     15'd16384, 1'b1, {14'd0,     1'b1}}, // empty the map
    '{CMD_ALLOC,   14'd0,     15'd16384, 1'b1, {14'd0,     1'b1}}, // whole map, hint wraps
    '{CMD_ALLOC,   14'd16383, 15'd1,     1'b1, {14'd0,     1'b0}},
    '{CMD_FREE,    14'd16383, 15'd1,     1'b1, {14'd0,     1'b1}},
    '{CMD_ALLOC,   14'd0,     15'd1,     1'b1, {14'd16383, 1'b1}}, // last frame
    '{CMD_FREE,    14'd16380, 15'd16384, 1'b1, {14'd0,     1'b1}}, // mostly past the end
    '{CMD_ALLOC,   14'd0,     15'd1,     1'b1, {14'd16380, 1'b1}},
    '{CMD_ALLOC,   14'd0,     15'd3,     1'b1, {14'd16381, 1'b1}}, // run ends at the end
    '{CMD_FREE,    14'd0,     15'd16384, 1'b1, {14'd0,     1'b1}},
    '{CMD_ALLOC,   14'd0,     15'd1,     1'b1, {14'd0,     1'b1}},
    '{CMD_ALLOC,   14'd0,     15'd16384, 1'b1, {14'd0,     1'b0}}, // run may not cross wrap
    '{CMD_ALLOC,   14'd0,     15'd16383, 1'b1, {14'd1,     1'b1}},
    '{CMD_RESERVE, 14'd0,     15'd16384, 1'b1, {14'd0,     1'b1}},
    '{CMD_FREE,    14'd40,    15'd24,    1'b1, {14'd0,     1'b1}},
    '{CMD_FREE,    14'd100,   15'd8,     1'b1, {14'd0,     1'b1}},
    '{CMD_ALLOC,   14'd0,     15'd30,    1'b1, {14'd0,     1'b0}}, // holes split by full word
    '{CMD_ALLOC,   14'd0,     15'd20,    1'b0, {14'd0,     1'b0}},
    '{CMD_ALLOC,   14'd0,     15'd8,     1'b0, {14'd0,     1'b0}},
    '{CMD_ALLOC,   14'd0,     15'd2,     1'b0, {14'd0,     1'b0}},
    '{CMD_FREE,    14'd12345, 15'd4000,  1'b0, {14'd0,     1'b0}}
  };

  // set or clear a range of shadow frames, dropping those past the end
  function automatic void mark_range(int unsigned first, int unsigned n, bit used);
    int unsigned f;
    for (int unsigned k = 0; k < n; k++) begin
      f = first + k;
      if (f < FRAMES) shadow_map[f / WORD_BITS][f % WORD_BITS] = used;
    end
  endfunction

  function automatic int lowest_free(int unsigned lo, int unsigned hi);
    for (int unsigned f = lo; f < hi; f++) begin
      if (!shadow_map[f / WORD_BITS][f % WORD_BITS]) return f;
    end
    return NO_FRAME;
  endfunction

  // next-fit run search: hint to the end, then 0 to the hint, run reset at wrap
  function automatic int first_run(int unsigned hint, int unsigned cnt);
    int unsigned i;
    int unsigned run;
    int unsigned start;
    bit          wrapped;
    i       = hint;
    run     = 0;
    start   = 0;
    wrapped = 1'b0;
    while (1) begin
      if (i >= FRAMES) begin
        if (wrapped) break;
        wrapped = 1'b1;
        i       = 0;
        run     = 0;
      end else if (wrapped && i >= hint) begin
        break;
      end else if (shadow_map[i / WORD_BITS] == '1) begin
        // fully used word: skip to the next word boundary
        run = 0;
        i   = (i + WORD_BITS) & ~(WORD_BITS - 1);
      end else begin
        if (!shadow_map[i / WORD_BITS][i % WORD_BITS]) begin
          if (run == 0) start = i;
          run++;
          if (run >= cnt) return start;
        end else begin
          run = 0;
        end
        i++;
      end
    end
    return NO_FRAME;
  endfunction

  // apply one request to the shadow state and return the grant it yields
  function automatic grant_t serve_request(logic [CMD_W-1:0] cmd, logic [FRAME_W-1:0] frame,
                                           logic [COUNT_W-1:0] count);
    grant_t      g;
    int          f;
    int unsigned n;
    g = '0;
    n = count;
    if (n != 0) begin
      case (cmd) inside
        CMD_ALLOC: begin
          if (n == 1) begin
            f = lowest_free(shadow_hint, FRAMES);
            if (f == NO_FRAME) f = lowest_free(0, shadow_hint);
          end else begin
            f = first_run(shadow_hint, n);
          end
          if (f != NO_FRAME) begin
            mark_range(f, n, 1'b1);
            shadow_hint = (f + n >= FRAMES) ? 0 : f + n;
            g.frame_out = f[FRAME_W-1:0];
            g.ok        = 1'b1;
          end
        end
        CMD_FREE, CMD_RESERVE: begin
          mark_range(frame, n, cmd == CMD_RESERVE);
          g.ok = 1'b1;
        end
        default: ;
      endcase
    end
    return g;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // mostly small counts, a few up to the whole map
  function automatic int unsigned pick_count();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 8);
    if (r < 90) return $urandom_range(9, 64);
    if (r < 98) return $urandom_range(65, 1024);
    return $urandom_range(1025, FRAMES);
  endfunction

  // random request: allocations and frees of granted blocks, plus noise
  function automatic void pick_request(input int unsigned idx, output logic [CMD_W-1:0] cmd,
                                       output logic [FRAME_W-1:0] frame,
                                       output logic [COUNT_W-1:0] count);
    int unsigned sel;
    int unsigned pos;
    block_t      b;
    sel   = $urandom_range(0, 99);
    cmd   = CMD_ALLOC;
    frame = FRAME_W'($urandom_range(0, FRAMES - 1));
    count = COUNT_W'(pick_count());
    if (idx % WIPE_EVERY == 0) begin
      // periodic wipe keeps fragmentation in check
      cmd   = CMD_FREE;
      frame = '0;
      count = COUNT_W'(FRAMES);
      held_blocks.delete();
    end else if (sel >= 45 && sel < 80 && held_blocks.size() != 0) begin
      pos   = $urandom_range(0, held_blocks.size() - 1);
      b     = held_blocks[pos];
      held_blocks.delete(pos);
      cmd   = CMD_FREE;
      frame = FRAME_W'(b.base);
      count = COUNT_W'(b.len);
    end else if (sel >= 80 && sel < 88) begin
      cmd = CMD_FREE;
    end else if (sel >= 88 && sel < 94) begin
      cmd   = CMD_RESERVE;
      count = COUNT_W'($urandom_range(1, 16));
    end else if (sel >= 94 && sel < 97) begin
      cmd   = CMD_W'($urandom_range(0, 3));
      count = '0;
    end else if (sel >= 97) begin
      cmd = CMD_UNUSED;
    end
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    if (mismatches <= MAX_PRINTS)
      $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // offer one transaction and hold it until the block takes it
  task automatic offer_request(logic [CMD_W-1:0] cmd, logic [FRAME_W-1:0] frame,
                               logic [COUNT_W-1:0] count, grant_t want);
    awaited_grants.push_back(want);
    req_if.cmd   <= cmd;
    req_if.frame <= frame;
    req_if.count <= count;
    req_if.valid <= 1'b1;
    do @(posedge clk); while (!req_if.ready);
  endtask

  task automatic sender_gap();
    int unsigned gap;
    gap = sender_quiet ? 0 : pick_gap();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // stimulus and end of run
  initial begin : stimulus
    logic [CMD_W-1:0]   cmd;
    logic [FRAME_W-1:0] frame;
    logic [COUNT_W-1:0] count;
    grant_t             g;
    rst_n        = 1'b0;
    req_if.valid = 1'b0;
    req_if.cmd   = '0;
    req_if.frame = '0;
    req_if.count = '0;
    mismatches   = 0;
    sender_quiet = 1'b0;
    foreach (shadow_map[w]) shadow_map[w] = '1;
    shadow_hint = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (directed_rows[r]) begin
      g = serve_request(directed_rows[r].cmd, directed_rows[r].frame, directed_rows[r].count);
      if (directed_rows[r].typed) g = directed_rows[r].want;
      offer_request(directed_rows[r].cmd, directed_rows[r].frame, directed_rows[r].count, g);
      sender_gap();
    end

    // random traffic
    for (int unsigned idx = 0; idx < RAND_ITEMS; idx++) begin
      if (idx % 100 == 0) sender_quiet = ($urandom_range(0, 3) == 0);
      if (idx == PAUSE_AT) begin
        // let the block run dry before going on
        req_if.valid <= 1'b0;
        do @(posedge clk); while (awaited_grants.size() != 0);
      end
      pick_request(idx, cmd, frame, count);
      g = serve_request(cmd, frame, count);
      if (cmd == CMD_ALLOC && g.ok) held_blocks.push_back('{g.frame_out, count});
      offer_request(cmd, frame, count, g);
      sender_gap();
    end
    req_if.valid <= 1'b0;

    // drain
    while (awaited_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS bitmap_frame_allocator_top");
    end else begin
      $display("FAIL bitmap_frame_allocator_top");
    end
    $finish;
  end

  // response side: check each transaction, stall at random
  initial begin : response_side
    grant_t      seen;
    grant_t      want;
    int unsigned stall;
    int unsigned taken;
    bit          held_off;
    bit          quiet;
    rsp_if.ready = 1'b0;
    stall        = 0;
    taken        = 0;
    held_off     = 1'b0;
    quiet        = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (rsp_if.valid && rsp_if.ready) begin
        seen = {rsp_if.frame_out, rsp_if.ok};
        if (awaited_grants.size() == 0) begin
          report_mismatch("response with no request outstanding", seen.frame_out, 0);
        end else begin
          want = awaited_grants.pop_front();
          if (seen.frame_out != want.frame_out)
            report_mismatch("frame_out", seen.frame_out, want.frame_out);
          if (seen.ok != want.ok) report_mismatch("ok", seen.ok, want.ok);
        end
        taken++;
        if (taken % 128 == 0) quiet = ($urandom_range(0, 3) == 0);
      end
      // one long hold-off so the block backs up into the request side
      if (!held_off && taken == HOLD_AFTER) begin
        held_off = 1'b1;
        stall    = HOLD_CYCLES;
      end else if (stall == 0 && !quiet && $urandom_range(0, 3) == 0) begin
        stall = pick_gap();
      end
      if (stall != 0) begin
        stall--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // cycle limit
  initial begin : watchdog
    longint cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL bitmap_frame_allocator_top");
    $finish;
  end

endmodule
